// ===== src/deque_with_value_search_macros.svh =====
// Assertion macros used by the deque controller (dqs_ctrl).
// Each macro takes a label, the clock, the reset, and the expressions to check.
`ifndef DEQUE_WITH_VALUE_SEARCH_MACROS_SVH
`define DEQUE_WITH_VALUE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DQS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DQS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define DQS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DQS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/dqs_pkg.sv =====
`timescale 1ns / 1ps

package dqs_pkg;

   // default configuration
   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // request operation codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_CONTAINS   = 3'd4;
   localparam logic [2:0] OP_REMOVE     = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_CLOSE,
      ST_DONE
   } state_type;

   // broadcast commands from the sequencer to the cell row
   typedef struct packed {
      logic push_front;  // every cell takes its front neighbour, cell 0 takes the key
      logic push_back;   // the cell at the count takes the key
      logic pop_front;   // every cell takes its back neighbour
      logic close;       // the cell at the scan position takes its back neighbour
   } cell_ctrl_type;

endpackage

// ===== src/dqs_req_if.sv =====
`timescale 1ns / 1ps

interface dqs_req_if #(
   parameter int VALUE_WIDTH = dqs_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    op;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== src/dqs_rsp_if.sv =====
`timescale 1ns / 1ps

interface dqs_rsp_if #(
   parameter int VALUE_WIDTH = dqs_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = $clog2(dqs_pkg::CAPACITY_DEF + 1)
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] front_value;
   logic signed [VALUE_WIDTH-1:0] back_value;
   logic [COUNT_WIDTH-1:0]        entry_count;
   logic                          is_empty;
   logic                          found;
   logic [1:0]                    status;

   modport source (output valid, output front_value, output back_value,
                   output entry_count, output is_empty, output found,
                   output status, input ready);
   modport sink   (input valid, input front_value, input back_value,
                   input entry_count, input is_empty, input found,
                   input status, output ready);
endinterface

// ===== src/dqs_cell.sv =====
`timescale 1ns / 1ps

module dqs_cell #(
   parameter int CAPACITY    = dqs_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = dqs_pkg::VALUE_WIDTH_DEF,
   parameter int INDEX       = 0,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int IW = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  dqs_pkg::cell_ctrl_type        ctrl,
   input  logic [CW-1:0]                 count,
   input  logic [IW-1:0]                 pos,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic signed [VALUE_WIDTH-1:0] prev_entry,
   input  logic signed [VALUE_WIDTH-1:0] next_entry,
   output logic signed [VALUE_WIDTH-1:0] entry,
   output logic                          hit
);

   localparam logic [CW-1:0] MY_COUNT_IDX = CW'(INDEX);
   localparam logic [IW-1:0] MY_POS_IDX   = IW'(INDEX);

   logic signed [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                          at_pos;

   assign at_pos = (pos == MY_POS_IDX);

   // entry update: shift from a neighbour or load the key
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_front) begin
         entry_in = (INDEX == 0) ? key : prev_entry;
      end else if (ctrl.push_back) begin
         if (count == MY_COUNT_IDX) entry_in = key;
      end else if (ctrl.pop_front) begin
         entry_in = next_entry;
      end else if (ctrl.close) begin
         if (at_pos) entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // match only reported where the scan token sits
   assign hit   = at_pos && (entry_ff == key);

endmodule

// ===== src/dqs_ctrl.sv =====
`timescale 1ns / 1ps
`include "deque_with_value_search_macros.svh"

module dqs_ctrl #(
   parameter int CAPACITY    = dqs_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = dqs_pkg::VALUE_WIDTH_DEF,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int IW = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic                          reset,
   dqs_req_if.sink                       req,
   dqs_rsp_if.source                     rsp,
   output dqs_pkg::cell_ctrl_type        cell_ctrl,
   output logic [CW-1:0]                 count,
   output logic [IW-1:0]                 pos,
   output logic signed [VALUE_WIDTH-1:0] key,
   input  logic signed [VALUE_WIDTH-1:0] entries [CAPACITY],
   input  logic [CAPACITY-1:0]           hits
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   dqs_pkg::state_type state_ff, state_in;

   logic [2:0]                    op_ff, op_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [IW-1:0]                 pos_ff, pos_in;
   logic                          found_ff, found_in;
   logic [1:0]                    status_ff, status_in;

   // response output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          load_rsp;
   logic signed [VALUE_WIDTH-1:0] front_ff, back_ff;
   logic [CW-1:0]                 cnt_out_ff;
   logic                          empty_ff, found_out_ff;
   logic [1:0]                    status_out_ff;

   logic [CW-1:0] last_sub;
   logic [IW-1:0] last_pos;
   logic          hit_any;
   logic          out_free;
   logic          at_last;

   assign last_sub = count_ff - CW'(1);
   assign last_pos = last_sub[IW-1:0];
   assign hit_any  = |hits;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign at_last  = (pos_ff == last_pos);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dqs_pkg::ST_IDLE: begin
            if (req.valid) state_in = dqs_pkg::ST_EXEC;
         end
         dqs_pkg::ST_EXEC: begin
            if ((op_ff == dqs_pkg::OP_CONTAINS || op_ff == dqs_pkg::OP_REMOVE) &&
                count_ff != '0) begin
               state_in = dqs_pkg::ST_SCAN;
            end else begin
               state_in = dqs_pkg::ST_DONE;
            end
         end
         dqs_pkg::ST_SCAN: begin
            if (hit_any) begin
               state_in = (op_ff == dqs_pkg::OP_REMOVE) ? dqs_pkg::ST_CLOSE
                                                         : dqs_pkg::ST_DONE;
            end else if (at_last) begin
               state_in = dqs_pkg::ST_DONE;
            end
         end
         dqs_pkg::ST_CLOSE: begin
            if (at_last) state_in = dqs_pkg::ST_DONE;
         end
         dqs_pkg::ST_DONE: begin
            if (out_free) state_in = dqs_pkg::ST_IDLE;
         end
         default: state_in = dqs_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req.ready = 1'b0;
      cell_ctrl = '0;
      op_in     = op_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      status_in = status_ff;
      load_rsp  = 1'b0;
      case (state_ff)
         dqs_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in     = req.op;
               key_in    = req.value;
               found_in  = 1'b0;
               status_in = dqs_pkg::STATUS_OK;
               pos_in    = '0;
            end
         end
         dqs_pkg::ST_EXEC: begin
            case (op_ff)
               dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_BACK: begin
                  if (count_ff == FULL_COUNT) begin
                     status_in = dqs_pkg::STATUS_FULL;
                  end else begin
                     cell_ctrl.push_front = (op_ff == dqs_pkg::OP_PUSH_FRONT);
                     cell_ctrl.push_back  = (op_ff == dqs_pkg::OP_PUSH_BACK);
                     count_in             = count_ff + CW'(1);
                  end
               end
               dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = dqs_pkg::STATUS_EMPTY;
                  end else begin
                     cell_ctrl.pop_front = (op_ff == dqs_pkg::OP_POP_FRONT);
                     count_in            = last_sub;
                  end
               end
               dqs_pkg::OP_CONTAINS, dqs_pkg::OP_REMOVE: begin
                  if (count_ff == '0) status_in = dqs_pkg::STATUS_EMPTY;
               end
               default: ;
            endcase
         end
         dqs_pkg::ST_SCAN: begin
            if (hit_any) begin
               found_in = 1'b1;
            end else if (!at_last) begin
               pos_in = pos_ff + IW'(1);
            end
         end
         dqs_pkg::ST_CLOSE: begin
            // walk the gap towards the back, one cell per cycle
            if (at_last) begin
               count_in = last_sub;
            end else begin
               cell_ctrl.close = 1'b1;
               pos_in          = pos_ff + IW'(1);
            end
         end
         dqs_pkg::ST_DONE: begin
            load_rsp = out_free;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (load_rsp) begin
         front_ff      <= (count_ff != '0) ? entries[0] : '0;
         back_ff       <= (count_ff != '0) ? entries[last_pos] : '0;
         cnt_out_ff    <= count_ff;
         empty_ff      <= (count_ff == '0);
         found_out_ff  <= found_ff;
         status_out_ff <= status_ff;
      end
   end

   assign count = count_ff;
   assign pos   = pos_ff;
   assign key   = key_ff;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.front_value = front_ff;
   assign rsp.back_value  = back_ff;
   assign rsp.entry_count = cnt_out_ff;
   assign rsp.is_empty    = empty_ff;
   assign rsp.found       = found_out_ff;
   assign rsp.status      = status_out_ff;

   `DQS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `DQS_ASSERT_IMP(a_scan_in_range, clock, reset,
                   state_ff == dqs_pkg::ST_SCAN || state_ff == dqs_pkg::ST_CLOSE,
                   CW'(pos_ff) < count_ff)
   `DQS_ASSERT_IMP(a_found_ok, clock, reset, rsp_valid_ff && found_out_ff,
                   status_out_ff == dqs_pkg::STATUS_OK)
   `DQS_ASSERT_NXT(a_close_shrinks, clock, reset,
                   state_ff == dqs_pkg::ST_CLOSE && at_last,
                   count_ff == $past(count_ff) - CW'(1))

endmodule

// ===== src/deque_with_value_search.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue of signed values with search and remove-by-value.
// Entries sit in a row of cells in order from front (cell 0) to back; push-front and
// pop-front shift the row, push-back loads the cell at the count and pop-back only
// lowers the count. One request is handled at a time: it is accepted in the idle
// state and carried out in the execute state; a contains or remove then scans the
// row up to the first match or the last entry, a remove that matches closes the gap
// up to the back, and the done state moves the result into the response register. A
// single scan token walks the row one cell per cycle, and the gap left by a removal
// is closed by the same walk. A new request is taken once the previous one has moved
// into the response register, even if the response is still waiting to be taken.
module deque_with_value_search #(
   parameter int CAPACITY    = dqs_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = dqs_pkg::VALUE_WIDTH_DEF,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int IW = $clog2(CAPACITY)
) (
   input  logic      clock,
   input  logic      reset,
   dqs_req_if.sink   req_chan,
   dqs_rsp_if.source rsp_chan
);

   dqs_pkg::cell_ctrl_type        cell_ctrl;
   logic [CW-1:0]                 count;
   logic [IW-1:0]                 pos;
   logic signed [VALUE_WIDTH-1:0] key;
   logic signed [VALUE_WIDTH-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]           hits;

   dqs_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .cell_ctrl (cell_ctrl),
      .count     (count),
      .pos       (pos),
      .key       (key),
      .entries   (entries),
      .hits      (hits)
   );

   // row of storage cells, each wired to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] prev_entry;
      logic signed [VALUE_WIDTH-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = key;
      end else begin : g_mid
         assign prev_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entries[i];
      end else begin : g_inner
         assign next_entry = entries[i+1];
      end

      dqs_cell #(
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count),
         .pos        (pos),
         .key        (key),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .hit        (hits[i])
      );
   end

endmodule
